// ===== rtl/core/bit_lane_range_mapper_unit_macros.svh =====
// assertion helpers for the bit lane range mapper
`ifndef BIT_LANE_RANGE_MAPPER_UNIT_MACROS_SVH
`define BIT_LANE_RANGE_MAPPER_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define BLRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define BLRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/blrm_pkg.sv =====
`default_nettype none

package blrm_pkg;

  // defaults for the top level parameters
  localparam int DefMaxBlocks = 16;
  localparam int DefMaxLanes  = 64;

  // fixed field widths
  localparam int WORD_W   = 32;
  localparam int LANE_W   = 6;
  localparam int CNT_W    = 7;
  localparam int IDX_O_W  = 4;
  localparam int STATUS_W = 3;
  localparam int REQ_W    = 2;
  localparam int DIV_CNT_W = $clog2(WORD_W);

  // lane count after reset
  localparam logic [CNT_W-1:0] LANE_COUNT_RST = 7'd32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_BIT   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_WORD  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MSB_OUT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_MAP   = 3'd4;

  // one mapping block as stored in the table
  typedef struct packed {
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] last_word;
    logic [LANE_W-1:0] low_lane;
    logic [LANE_W-1:0] high_lane;
  } entry_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [CNT_W-1:0]  remainder;
  } div_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/blrm_if.sv =====
`default_nettype none

// request channel
interface blrm_req_if;
  logic                          valid;
  logic                          ready;
  logic [blrm_pkg::REQ_W-1:0]    req_type;
  logic [blrm_pkg::WORD_W-1:0]   address;
  logic [blrm_pkg::WORD_W-1:0]   block_start;
  logic [blrm_pkg::WORD_W-1:0]   block_end;
  logic [blrm_pkg::LANE_W-1:0]   block_lsb;
  logic [blrm_pkg::LANE_W-1:0]   block_msb;

  modport source (
    output valid, req_type, address, block_start, block_end, block_lsb, block_msb,
    input  ready
  );
  modport sink (
    input  valid, req_type, address, block_start, block_end, block_lsb, block_msb,
    output ready
  );
endinterface

// result channel
interface blrm_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [blrm_pkg::STATUS_W-1:0]  status;
  logic                           hit;
  logic [blrm_pkg::IDX_O_W-1:0]   entry_index;
  logic [blrm_pkg::LANE_W-1:0]    lane;
  logic [blrm_pkg::WORD_W-1:0]    word_num;
  logic                           last;

  modport source (
    output valid, status, hit, entry_index, lane, word_num, last,
    input  ready
  );
  modport sink (
    input  valid, status, hit, entry_index, lane, word_num, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/blrm_ram.sv =====
`default_nettype none

// simple dual port ram, one write and one registered read
module blrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/blrm_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module blrm_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [blrm_pkg::WORD_W-1:0]   dividend_i,
  input  wire logic [blrm_pkg::CNT_W-1:0]    divisor_i,
  output blrm_pkg::div_res_t                 res_o
);

  localparam int WW = blrm_pkg::WORD_W;
  localparam int CW = blrm_pkg::CNT_W;
  localparam int KW = blrm_pkg::DIV_CNT_W;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [KW-1:0] cnt_q, cnt_d;
  logic [WW-1:0] quo_q, quo_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] dvs_q, dvs_d;
  logic [CW:0]   trial;
  logic [CW:0]   diff;

  // trial subtract of the shifted partial remainder
  assign trial = {rem_q, quo_q[WW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[CW-1:0];
        quo_d = {quo_q[WW-2:0], 1'b1};
      end else begin
        rem_d = trial[CW-1:0];
        quo_d = {quo_q[WW-2:0], 1'b0};
      end
      cnt_d = cnt_q + KW'(1);
      // last quotient bit
      if (cnt_q == KW'(WW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign res_o.busy      = busy_q;
  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/bit_lane_range_mapper_unit.sv =====
`default_nettype none
// Bit lane range mapper. Keeps up to MAX_BLOCKS mapping blocks (word range
// and lane slice) in a small RAM and answers add, clear, bit and word
// requests, one request at a time; the request side is ready only while the
// block is idle. Add and clear pass through S_SINGLE, which loads their
// result into the output register once that register is free. A bit lookup
// first divides the address by the lane count in a serial divider, then
// scans the table newest first through the single RAM read port, then loads
// one result. A word lookup skips the division and scans the table once for
// each lane, loading one result per lane while the output is taken. A
// finished result waits in an output register, so a new request is taken
// while the last result of the previous one is still unread.
`include "bit_lane_range_mapper_unit_macros.svh"

module bit_lane_range_mapper_unit #(
  parameter int MAX_BLOCKS = blrm_pkg::DefMaxBlocks,
  parameter int MAX_LANES  = blrm_pkg::DefMaxLanes
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [blrm_pkg::CNT_W-1:0]   cfg_wdata_i,
  blrm_req_if.sink                          req_i,
  blrm_rsp_if.source                        rsp_o
);

  localparam int WW     = blrm_pkg::WORD_W;
  localparam int LW     = blrm_pkg::LANE_W;
  localparam int CW     = blrm_pkg::CNT_W;
  localparam int OW     = blrm_pkg::IDX_O_W;
  localparam int SW     = blrm_pkg::STATUS_W;
  localparam int RW     = blrm_pkg::REQ_W;
  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int TOT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int EXT_W  = (TOT_W > OW) ? TOT_W : OW;
  localparam int LIDX_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int ENT_W  = $bits(blrm_pkg::entry_t);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SINGLE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     lane_count_q;
  logic [TOT_W-1:0]  total_q, total_d;
  logic [TOT_W-1:0]  scan_left_q, scan_left_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;

  // captured request
  logic [RW-1:0]     type_q;
  logic [WW-1:0]     start_q;
  logic [WW-1:0]     end_q;
  logic [LW-1:0]     lsb_q;
  logic [LW-1:0]     msb_q;
  logic [WW-1:0]     word_q, word_d;
  logic [LIDX_W-1:0] out_lane_q, out_lane_d;

  // newest covering entry found by the scan of the current lane
  logic              found_q, found_d;
  logic [IDX_W-1:0]  found_idx_q, found_idx_d;

  // output register
  logic              rsp_valid_q, rsp_valid_d;
  logic [SW-1:0]     rsp_status_q, rsp_status_d;
  logic              rsp_hit_q, rsp_hit_d;
  logic [OW-1:0]     rsp_idx_q, rsp_idx_d;
  logic [LW-1:0]     rsp_lane_q, rsp_lane_d;
  logic [WW-1:0]     rsp_word_q, rsp_word_d;
  logic              rsp_last_q, rsp_last_d;

  logic              req_fire;
  logic              rsp_free;
  logic              rsp_load;
  logic [CW-1:0]     lanes;
  logic              div_start;
  blrm_pkg::div_res_t div_res;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  blrm_pkg::entry_t  wr_entry;
  blrm_pkg::entry_t  rd_entry;
  logic [ENT_W-1:0]  rd_bits;
  logic              entry_match;
  logic              out_last;
  logic [EXT_W-1:0]  total_ext;
  logic [EXT_W-1:0]  hit_idx_ext;
  logic [TOT_W-1:0]  scan_next;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // effective lane count, zero acts as one and large values saturate
  always_comb begin
    if (lane_count_q == '0) begin
      lanes = CW'(1);
    end else if (lane_count_q > CW'(MAX_LANES)) begin
      lanes = CW'(MAX_LANES);
    end else begin
      lanes = lane_count_q;
    end
  end

  // serial divider for the bit address split
  assign div_start = req_fire && (req_i.req_type == blrm_pkg::REQ_BIT);

  blrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_i.address),
    .divisor_i  (lanes),
    .res_o      (div_res)
  );

  // block table
  assign wr_entry.first_word = start_q;
  assign wr_entry.last_word  = end_q;
  assign wr_entry.low_lane   = lsb_q;
  assign wr_entry.high_lane  = msb_q;
  assign rd_entry = blrm_pkg::entry_t'(rd_bits);

  assign scan_next = scan_left_q - TOT_W'(1);
  assign ram_raddr = scan_next[IDX_W-1:0];

  blrm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (total_q[IDX_W-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (ram_raddr),
    .rdata_o (rd_bits)
  );

  // shared word range and lane slice compare for the entry being scanned
  assign entry_match = (rd_entry.first_word <= word_q) && (word_q <= rd_entry.last_word) &&
                       (rd_entry.low_lane <= LW'(out_lane_q)) &&
                       (LW'(out_lane_q) <= rd_entry.high_lane);

  assign total_ext   = EXT_W'(total_q);
  assign hit_idx_ext = EXT_W'(found_idx_q);
  assign out_last = (type_q == blrm_pkg::REQ_BIT) ||
                    ((CW'(out_lane_q) + CW'(1)) == lanes);

  // sequencer
  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    scan_left_d = scan_left_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    word_d      = word_q;
    out_lane_d  = out_lane_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    ram_we      = 1'b0;
    rsp_load    = 1'b0;
    rsp_status_d = rsp_status_q;
    rsp_hit_d    = rsp_hit_q;
    rsp_idx_d    = rsp_idx_q;
    rsp_lane_d   = rsp_lane_q;
    rsp_word_d   = rsp_word_q;
    rsp_last_d   = rsp_last_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          case (req_i.req_type)
            blrm_pkg::REQ_BIT: begin
              state_d = S_DIV;
            end
            blrm_pkg::REQ_WORD: begin
              word_d      = req_i.address;
              out_lane_d  = '0;
              scan_left_d = total_q;
              found_d     = 1'b0;
              state_d     = S_SCAN;
            end
            default: begin
              state_d = S_SINGLE;
            end
          endcase
        end
      end
      S_SINGLE: begin
        if (rsp_free) begin
          rsp_load     = 1'b1;
          rsp_hit_d    = 1'b0;
          rsp_lane_d   = '0;
          rsp_word_d   = '0;
          rsp_last_d   = 1'b1;
          rsp_idx_d    = '0;
          rsp_status_d = blrm_pkg::ST_OK;
          if (type_q == blrm_pkg::REQ_CLEAR) begin
            total_d = '0;
          end else if ((start_q > end_q) || (lsb_q > msb_q)) begin
            rsp_status_d = blrm_pkg::ST_INVERTED;
          end else if (CW'(msb_q) >= lanes) begin
            rsp_status_d = blrm_pkg::ST_MSB_OUT;
          end else if (total_q >= TOT_W'(MAX_BLOCKS)) begin
            rsp_status_d = blrm_pkg::ST_FULL;
          end else begin
            ram_we    = 1'b1;
            rsp_idx_d = total_ext[OW-1:0];
            total_d   = total_q + TOT_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          word_d      = div_res.quotient;
          out_lane_d  = div_res.remainder[LIDX_W-1:0];
          scan_left_d = total_q;
          found_d     = 1'b0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        // first covering entry seen is the newest one
        if (rd_vld_q && !found_q && entry_match) begin
          found_d     = 1'b1;
          found_idx_d = rd_idx_q;
        end
        // one read issued and one entry compared per cycle
        if (scan_left_q != '0) begin
          rd_vld_d    = 1'b1;
          rd_idx_d    = ram_raddr;
          scan_left_d = scan_next;
        end else if (!rd_vld_q) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (rsp_free) begin
          rsp_load   = 1'b1;
          rsp_lane_d = LW'(out_lane_q);
          rsp_word_d = word_q;
          rsp_last_d = out_last;
          rsp_hit_d  = found_q;
          if (found_q) begin
            rsp_status_d = blrm_pkg::ST_OK;
            rsp_idx_d    = hit_idx_ext[OW-1:0];
          end else begin
            rsp_status_d = blrm_pkg::ST_NO_MAP;
            rsp_idx_d    = '0;
          end
          if (out_last) begin
            state_d = S_IDLE;
          end else begin
            // next lane, scan the table again
            out_lane_d  = out_lane_q + LIDX_W'(1);
            scan_left_d = total_q;
            found_d     = 1'b0;
            state_d     = S_SCAN;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      lane_count_q <= blrm_pkg::LANE_COUNT_RST;
      total_q      <= '0;
      scan_left_q  <= '0;
      rd_vld_q     <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      scan_left_q <= scan_left_d;
      rd_vld_q    <= rd_vld_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        lane_count_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      type_q  <= req_i.req_type;
      start_q <= req_i.block_start;
      end_q   <= req_i.block_end;
      lsb_q   <= req_i.block_lsb;
      msb_q   <= req_i.block_msb;
    end
    rd_idx_q     <= rd_idx_d;
    word_q       <= word_d;
    out_lane_q   <= out_lane_d;
    found_q      <= found_d;
    found_idx_q  <= found_idx_d;
    rsp_status_q <= rsp_status_d;
    rsp_hit_q    <= rsp_hit_d;
    rsp_idx_q    <= rsp_idx_d;
    rsp_lane_q   <= rsp_lane_d;
    rsp_word_q   <= rsp_word_d;
    rsp_last_q   <= rsp_last_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.hit         = rsp_hit_q;
  assign rsp_o.entry_index = rsp_idx_q;
  assign rsp_o.lane        = rsp_lane_q;
  assign rsp_o.word_num    = rsp_word_q;
  assign rsp_o.last        = rsp_last_q;

  // checks
  `BLRM_ASSERT_IMP(a_total_bound, clk_i, rst_ni, 1'b1, total_q <= TOT_W'(MAX_BLOCKS), "table count overflow")
  `BLRM_ASSERT_IMP(a_hit_ok, clk_i, rst_ni, rsp_valid_q && rsp_hit_q, rsp_status_q == blrm_pkg::ST_OK, "hit without ok status")
  `BLRM_ASSERT_IMP(a_div_in_state, clk_i, rst_ni, div_res.busy, state_q == S_DIV, "divider busy outside division")
  `BLRM_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, req_fire, state_q != S_IDLE, "idle straight after request")

endmodule

`default_nettype wire
